// ----- rtl/blr_pkg.sv -----
// Package for the Bresenham line rasterizer: widths, item types and the
// command record passed from the front decode to the stepping back end.
// No dependencies.
package blr_pkg;

  // Coordinate width and derived widths
  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;  // |end - start| and step count
  localparam int ERR_BITS   = COORD_BITS + 3;  // signed decision error

  // Command queue depth
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  // Item function codes
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Input item
  typedef struct packed {
    logic                         func;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] y_end;
  } blr_in_t;

  // Result item
  typedef struct packed {
    logic                         pixel_valid;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last_pixel;
  } blr_out_t;

  // Decoded command held in the queue
  typedef struct packed {
    logic                  is_start;
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] y0;
    logic [DELTA_BITS-1:0] dx;
    logic [DELTA_BITS-1:0] dy;
    logic                  step_x_neg;
    logic                  step_y_neg;
  } blr_cmd_t;

endpackage

// ----- rtl/blr_front.sv -----
// Front decode of the line rasterizer: classifies each item and, for a
// start item, forms absolute deltas and step directions.
// Depends on blr_pkg.
module blr_front import blr_pkg::*; (
  input  blr_in_t  item,
  output blr_cmd_t cmd
);

  logic signed [DELTA_BITS-1:0] diff_x;
  logic signed [DELTA_BITS-1:0] diff_y;
  logic                         neg_x;
  logic                         neg_y;

  // Take signed differences at one extra bit
  assign diff_x = DELTA_BITS'(item.x_end) - DELTA_BITS'(item.x_start);
  assign diff_y = DELTA_BITS'(item.y_end) - DELTA_BITS'(item.y_start);
  assign neg_x  = diff_x[DELTA_BITS-1];
  assign neg_y  = diff_y[DELTA_BITS-1];

  // Build the command record
  always_comb begin
    cmd.is_start   = (item.func == FUNC_START);
    cmd.x0         = item.x_start;
    cmd.y0         = item.y_start;
    cmd.dx         = neg_x ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
    cmd.dy         = neg_y ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);
    cmd.step_x_neg = neg_x;
    cmd.step_y_neg = neg_y;
  end

endmodule

// ----- rtl/blr_queue.sv -----
// Short command queue between the rasterizer front and back end, built
// from flip-flops with one write and one read place per cycle.
// Depends on blr_pkg.
module blr_queue import blr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  blr_cmd_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output blr_cmd_t rd_data
);

  blr_cmd_t                entry_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0]   count_r, count_nxt;
  logic                    push;
  logic                    pop;

  assign wr_ready = (count_r != Q_CNT_BITS'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the written command
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/blr_back.sv -----
// Back end of the line rasterizer: holds the line state, applies the
// decision-error step per command and drives the result register.
// Depends on blr_pkg.
module blr_back import blr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  blr_cmd_t cmd,
  output logic     out_valid,
  input  logic     out_ready,
  output blr_out_t out_data
);

  logic [COORD_BITS-1:0]      cur_x_r, cur_x_nxt;
  logic [COORD_BITS-1:0]      cur_y_r, cur_y_nxt;
  logic signed [ERR_BITS-1:0] err_r, err_nxt;
  logic signed [ERR_BITS-1:0] inc_minor_r, inc_minor_nxt;
  logic signed [ERR_BITS-1:0] inc_major_r, inc_major_nxt;
  logic [DELTA_BITS-1:0]      steps_r, steps_nxt;
  logic                       sx_neg_r, sx_neg_nxt;
  logic                       sy_neg_r, sy_neg_nxt;
  logic                       x_major_r, x_major_nxt;
  logic                       active_r, active_nxt;
  logic                       out_valid_r;
  blr_out_t                   out_data_r, out_data_nxt;

  logic                       take;
  logic                       x_major_new;
  logic [DELTA_BITS-1:0]      major;
  logic [DELTA_BITS-1:0]      minor;
  logic [ERR_BITS-1:0]        minor2;
  logic [ERR_BITS-1:0]        major2;
  logic [COORD_BITS-1:0]      step_x;
  logic [COORD_BITS-1:0]      step_y;
  logic                       minor_step;
  logic [DELTA_BITS-1:0]      steps_dec;

  // Take a command when the result register is free or being drained
  assign cmd_ready = out_ready || !out_valid_r;
  assign take      = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Start set-up: pick major axis, form error terms
  assign x_major_new = (cmd.dx > cmd.dy);
  assign major       = x_major_new ? cmd.dx : cmd.dy;
  assign minor       = x_major_new ? cmd.dy : cmd.dx;
  assign minor2      = {1'b0, minor, 1'b0};
  assign major2      = {1'b0, major, 1'b0};

  // Step terms
  assign step_x     = sx_neg_r ? '1 : COORD_BITS'(1);
  assign step_y     = sy_neg_r ? '1 : COORD_BITS'(1);
  assign minor_step = !err_r[ERR_BITS-1];
  assign steps_dec  = steps_r - 1'b1;

  // Next line state and result
  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    err_nxt       = err_r;
    inc_minor_nxt = inc_minor_r;
    inc_major_nxt = inc_major_r;
    steps_nxt     = steps_r;
    sx_neg_nxt    = sx_neg_r;
    sy_neg_nxt    = sy_neg_r;
    x_major_nxt   = x_major_r;
    active_nxt    = active_r;
    out_data_nxt  = '0;
    if (cmd.is_start) begin
      cur_x_nxt     = cmd.x0;
      cur_y_nxt     = cmd.y0;
      err_nxt       = minor2 - {2'b00, major};
      inc_minor_nxt = minor2 - major2;
      inc_major_nxt = minor2;
      steps_nxt     = major;
      sx_neg_nxt    = cmd.step_x_neg;
      sy_neg_nxt    = cmd.step_y_neg;
      x_major_nxt   = x_major_new;
      active_nxt    = (major != '0);
      out_data_nxt.pixel_valid = 1'b1;
      out_data_nxt.pixel_x     = cmd.x0;
      out_data_nxt.pixel_y     = cmd.y0;
      out_data_nxt.last_pixel  = (major == '0);
    end else if (active_r) begin
      if (minor_step) begin
        err_nxt = err_r + inc_minor_r;
      end else begin
        err_nxt = err_r + inc_major_r;
      end
      if (x_major_r) begin
        cur_x_nxt = cur_x_r + step_x;
        cur_y_nxt = minor_step ? cur_y_r + step_y : cur_y_r;
      end else begin
        cur_y_nxt = cur_y_r + step_y;
        cur_x_nxt = minor_step ? cur_x_r + step_x : cur_x_r;
      end
      steps_nxt  = steps_dec;
      active_nxt = (steps_dec != '0);
      out_data_nxt.pixel_valid = 1'b1;
      out_data_nxt.pixel_x     = cur_x_nxt;
      out_data_nxt.pixel_y     = cur_y_nxt;
      out_data_nxt.last_pixel  = (steps_dec == '0);
    end
  end

  // Hold line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      err_r       <= '0;
      inc_minor_r <= '0;
      inc_major_r <= '0;
      steps_r     <= '0;
      sx_neg_r    <= 1'b0;
      sy_neg_r    <= 1'b0;
      x_major_r   <= 1'b0;
      active_r    <= 1'b0;
    end else if (take) begin
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      err_r       <= err_nxt;
      inc_minor_r <= inc_minor_nxt;
      inc_major_r <= inc_major_nxt;
      steps_r     <= steps_nxt;
      sx_neg_r    <= sx_neg_nxt;
      sy_neg_r    <= sy_neg_nxt;
      x_major_r   <= x_major_nxt;
      active_r    <= active_nxt;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

// ----- rtl/bresenham_line_rasterizer.sv -----
// Top level of the Bresenham line rasterizer: front decode, command queue
// and stepping back end. Depends on blr_pkg, blr_front, blr_queue, blr_back.
//
// Usage: each input item on in_valid/in_ready/in_data gives exactly one
// result item on out_valid/out_ready/out_data. A start item (func 0) loads
// both endpoints and returns the first endpoint; each step item (func 1)
// returns the next pixel, last_pixel marking the line's final endpoint.
// A step with no line in progress returns pixel_valid 0 with zero fields.
// An accepted item is written into the queue; the back end loads its
// result into the result register when it takes the command from it.
// Throughput: one item per cycle while the receiver takes results, as
// the back end does one error update per command; the queue and result
// register keep the input side taking items while a result waits. When
// the receiver stalls, the result register holds and the queue fills;
// in_ready drops once both queue entries are occupied. Reset (rst_n low,
// synchronous) empties the queue, drops the result and leaves the block
// with no line in progress.
module bresenham_line_rasterizer import blr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  blr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output blr_out_t out_data
);

  blr_cmd_t front_cmd;
  blr_cmd_t q_cmd;
  logic     q_valid;
  logic     q_ready;

  // Decode incoming items
  blr_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  // Buffer decoded commands
  blr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_valid),
    .wr_ready (in_ready),
    .wr_data  (front_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  // Step the line and drive results
  blr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
